// ===== hdl/ctp_pkg.sv =====
// Shared types and constants for the cost-balanced task packer.
// Used by the controller, the datapath and the top level; no dependencies.
package ctp_pkg;

	localparam int unsigned MAX_CHUNKS = 31;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	localparam logic [1:0] KIND_ITEM   = 2'd0;
	localparam logic [1:0] KIND_CLOSE  = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic        REG_CHUNK_COST   = 1'b0;
	localparam logic [31:0] CHUNK_COST_RESET = 32'd1024;

	typedef struct packed {
		logic               command;
		logic [1:0]         channel;
		logic [30:0]        group_id;
		logic signed [31:0] partner_group;
		logic [31:0]        group_size;
	} entry_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         out_channel;
		logic [30:0]        out_group;
		logic signed [31:0] out_partner;
		logic [31:0]        row_start;
		logic [31:0]        row_end;
		logic [31:0]        task_index;
		logic [33:0]        task_cost;
		logic [47:0]        rows_total;
		logic               is_last;
	} result_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_ITEM,
		OP_CLOSE,
		OP_REJECT
	} emit_op_t;

	typedef struct packed {
		logic     latch;
		logic     chunk;
		emit_op_t op;
		logic     last;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_flush;
		logic size_zero;
		logic reject;
		logic open_nonempty;
		logic final_chunk;
		logic need_pre;
		logic need_post;
		logic slot_free;
	} dp_status_t;

endpackage

// ===== hdl/ctp_datapath.sv =====
// Datapath of the task packer: entry registers, chunk stage, task state and
// the output register. Depends on ctp_pkg; driven by ctp_controller.
module ctp_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         chunk_cost,
	input  ctp_pkg::entry_t     entry,
	input  ctp_pkg::ctl_cmd_t   cmd,
	output ctp_pkg::dp_status_t status,
	output logic                result_valid,
	input  logic                result_ready,
	output ctp_pkg::result_t    result
);
	import ctp_pkg::*;

	entry_t      entry_q;
	logic [31:0] start_q;
	logic [31:0] cost_s1;
	logic [31:0] end_s1;
	logic        final_s1;
	logic [33:0] open_cost_q;
	logic        open_nonempty_q;
	logic [31:0] task_counter_q;
	logic [47:0] cost_sum_q;
	result_t     result_q;
	logic        valid_q;

	logic [31:0] remaining;
	logic        rem_fits;
	logic [36:0] max_rows;
	logic [34:0] open_sum;
	logic [34:0] limit;
	result_t     next_result;

	assign remaining = entry_q.group_size - start_q;
	assign rem_fits  = remaining <= chunk_cost;
	// Largest group that still fits in MAX_CHUNKS row ranges.
	assign max_rows  = 37'(chunk_cost) * 37'(MAX_CHUNKS);
	assign open_sum  = {1'b0, open_cost_q} + {3'b0, cost_s1};
	assign limit     = {3'b0, chunk_cost} + {4'b0, chunk_cost[31:1]};

	always_comb begin
		status.is_flush      = entry_q.command == CMD_FLUSH;
		status.size_zero     = entry_q.group_size == 32'd0;
		status.reject        = {5'b0, entry_q.group_size} > max_rows;
		status.open_nonempty = open_nonempty_q;
		status.final_chunk   = final_s1;
		status.need_pre      = open_nonempty_q && (open_sum > limit);
		status.need_post     = open_sum >= {3'b0, chunk_cost};
		status.slot_free     = !valid_q || result_ready;
	end

	always_comb begin
		next_result            = '0;
		next_result.task_index = task_counter_q;
		next_result.rows_total = cost_sum_q;
		next_result.is_last    = cmd.last;
		case (cmd.op)
			OP_ITEM: begin
				next_result.kind        = KIND_ITEM;
				next_result.out_channel = entry_q.channel;
				next_result.out_group   = entry_q.group_id;
				next_result.out_partner = entry_q.partner_group;
				next_result.row_start   = start_q;
				next_result.row_end     = end_s1;
			end
			OP_CLOSE: begin
				next_result.kind      = KIND_CLOSE;
				next_result.task_cost = open_cost_q;
			end
			OP_REJECT: begin
				next_result.kind        = KIND_REJECT;
				next_result.out_channel = entry_q.channel;
				next_result.out_group   = entry_q.group_id;
				next_result.out_partner = entry_q.partner_group;
				next_result.row_end     = entry_q.group_size;
			end
			default: begin
				next_result.kind = KIND_ITEM;
			end
		endcase
	end

	// Entry and chunk registers carry payload only.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			entry_q <= entry;
		end
		if (cmd.chunk) begin
			final_s1 <= rem_fits;
			cost_s1  <= rem_fits ? remaining : chunk_cost;
			end_s1   <= rem_fits ? entry_q.group_size : start_q + chunk_cost;
		end
		if (cmd.op != OP_NONE) begin
			result_q <= next_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q         <= '0;
			open_cost_q     <= '0;
			open_nonempty_q <= 1'b0;
			task_counter_q  <= '0;
			cost_sum_q      <= '0;
			valid_q         <= 1'b0;
		end else begin
			if (cmd.latch) begin
				start_q <= '0;
			end
			// The running sum takes the range before any close ahead of it.
			if (cmd.chunk) begin
				cost_sum_q <= cost_sum_q + {16'b0, (rem_fits ? remaining : chunk_cost)};
			end
			case (cmd.op)
				OP_ITEM: begin
					open_cost_q     <= open_sum[33:0];
					open_nonempty_q <= 1'b1;
					start_q         <= end_s1;
				end
				OP_CLOSE: begin
					task_counter_q  <= task_counter_q + 32'd1;
					open_cost_q     <= '0;
					open_nonempty_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (cmd.op != OP_NONE) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

	a_empty_task_no_cost: assert property (@(posedge clk) disable iff (!arst_n)
		!open_nonempty_q |-> open_cost_q == 34'd0)
		else $error("empty task holds a nonzero cost");

	a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op != OP_NONE |-> (!valid_q || result_ready))
		else $error("result overwrites an untaken transaction");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_ready) |=> (valid_q && $stable(result_q)))
		else $error("waiting result transaction dropped or changed");

endmodule

// ===== hdl/ctp_controller.sv =====
// Sequencer of the task packer: walks each entry through check, chunk,
// close and emit steps. Depends on ctp_pkg; commands ctp_datapath.
module ctp_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                entry_valid,
	output logic                entry_ready,
	input  ctp_pkg::dp_status_t status,
	output ctp_pkg::ctl_cmd_t   cmd
);
	import ctp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_CHUNK,
		S_PRE,
		S_ITEM,
		S_POST,
		S_REJECT,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		cmd.op      = OP_NONE;
		entry_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				entry_ready = 1'b1;
				if (entry_valid) begin
					cmd.latch = 1'b1;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.is_flush) begin
					state_nxt = status.open_nonempty ? S_FLUSH : S_IDLE;
				end else if (status.size_zero) begin
					state_nxt = S_IDLE;
				end else if (status.reject) begin
					state_nxt = S_REJECT;
				end else begin
					state_nxt = S_CHUNK;
				end
			end
			S_CHUNK: begin
				cmd.chunk = 1'b1;
				state_nxt = S_PRE;
			end
			S_PRE: begin
				if (!status.need_pre) begin
					state_nxt = S_ITEM;
				end else if (status.slot_free) begin
					cmd.op    = OP_CLOSE;
					state_nxt = S_ITEM;
				end
			end
			S_ITEM: begin
				if (status.slot_free) begin
					cmd.op   = OP_ITEM;
					cmd.last = status.final_chunk && !status.need_post;
					if (status.need_post) begin
						state_nxt = S_POST;
					end else begin
						state_nxt = status.final_chunk ? S_IDLE : S_CHUNK;
					end
				end
			end
			S_POST: begin
				if (status.slot_free) begin
					cmd.op    = OP_CLOSE;
					cmd.last  = status.final_chunk;
					state_nxt = status.final_chunk ? S_IDLE : S_CHUNK;
				end
			end
			S_REJECT: begin
				if (status.slot_free) begin
					cmd.op    = OP_REJECT;
					cmd.last  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (status.slot_free) begin
					cmd.op    = OP_CLOSE;
					cmd.last  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_accept_goes_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_valid && entry_ready) |=> state_q == S_CHECK)
		else $error("accepted entry not checked next");

	a_last_ends_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != OP_NONE && cmd.last) |=> state_q == S_IDLE)
		else $error("work continues after the last result of an entry");

	a_chunk_then_pre: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.chunk |=> state_q == S_PRE)
		else $error("chunk step not followed by the close check");

endmodule

// ===== hdl/cost_balanced_task_packer_core.sv =====
// Top level of the cost-balanced task packer: register port, controller
// and datapath. Depends on ctp_pkg, ctp_controller and ctp_datapath.
//
//   port group    direction  handshake               payload
//   entry         in         entry_valid/ready       ctp_pkg::entry_t
//   result        out        result_valid/ready      ctp_pkg::result_t
//   register      in/out     psel/penable/pready     paddr, pwdata, prdata
//
// An entry is latched in S_IDLE and checked in S_CHECK; a zero-size entry or an empty flush ends there.
// Each row range then passes S_CHUNK, S_PRE (with a close ahead of it if needed) and
// S_ITEM, plus S_POST when the task closes after it.
// A flush close or a rejection is emitted from S_FLUSH or S_REJECT after the check.
// arst_n clears the task state and sets chunk_cost to 1024.
// A stalled result holds the sequencer at its next emit step; entries wait meanwhile.
module cost_balanced_task_packer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             entry_valid,
	output logic             entry_ready,
	input  ctp_pkg::entry_t  entry,
	output logic             result_valid,
	input  logic             result_ready,
	output ctp_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import ctp_pkg::*;

	logic        reg_index;
	logic [31:0] chunk_cost_q;
	ctl_cmd_t    cmd;
	dp_status_t  status;

	// Registers sit on 32-bit words, so the word index is the top address bit.
	assign reg_index = paddr[2];
	assign pready    = 1'b1;
	assign prdata    = (reg_index == REG_CHUNK_COST) ? chunk_cost_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_cost_q <= CHUNK_COST_RESET;
		end else if (psel && penable && pwrite && reg_index == REG_CHUNK_COST) begin
			chunk_cost_q <= pwdata;
		end
	end

	ctp_controller u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (entry_valid),
		.entry_ready (entry_ready),
		.status      (status),
		.cmd         (cmd)
	);

	ctp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.chunk_cost   (chunk_cost_q),
		.entry        (entry),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
